[rtl/sptk_pkg.sv]
// ----------------------------------------------------------------------------
// sptk_pkg: shared types and constants of the sorted key table
// Widths, table depth, the per-cell payload and control structs, and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sptk_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 64;
  localparam int unsigned THR_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // One table entry as held by a cell.
  typedef struct packed {
    logic [KEY_W-1:0] primary;
    logic [KEY_W-1:0] secondary;
    logic [THR_W-1:0] threshold;
  } cell_data_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic capture;  // latch the compare flags against the incoming key
    logic insert;   // open a slot at the boundary and shift the tail up
    logic update;   // overwrite the threshold of the matching cell
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_WRITE = 2'b10
  } seq_state_e;

endpackage

[rtl/sptk_cell.sv]
// ----------------------------------------------------------------------------
// sptk_cell: one slot of the sorted table
// Compares its entry with the incoming key, keeps the result, and on insert
// either takes the new entry or the entry of its lower neighbor.
// ----------------------------------------------------------------------------
module sptk_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sptk_pkg::cell_ctrl_t        ctrl_i,
  input  logic [sptk_pkg::IDX_W-1:0]  index_i,
  input  logic [sptk_pkg::CNT_W-1:0]  count_i,
  input  logic [sptk_pkg::KEY_W-1:0]  probe_primary_i,
  input  logic [sptk_pkg::KEY_W-1:0]  probe_secondary_i,
  input  sptk_pkg::cell_data_t        new_i,
  input  sptk_pkg::cell_data_t        prev_data_i,
  input  logic                        prev_after_i,
  output sptk_pkg::cell_data_t        data_o,
  output logic                        after_o,
  output logic                        match_o
);
  import sptk_pkg::*;

  cell_data_t data_q;
  logic       after_q;
  logic       match_q;
  logic       occupied;
  logic       ge;
  logic       eq;

  // A slot above the fill level counts as ordering after any key, so the
  // after flags form a thermometer whose lowest set bit is the target slot.
  assign occupied = {1'b0, index_i} < count_i;
  assign eq = (data_q.primary == probe_primary_i) && (data_q.secondary == probe_secondary_i);
  assign ge = (data_q.primary != probe_primary_i) ? (data_q.primary > probe_primary_i)
                                                  : (data_q.secondary >= probe_secondary_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_q <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      after_q <= ~occupied | ge;
      match_q <= occupied & eq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && after_q) begin
      data_q <= prev_after_i ? prev_data_i : new_i;
    end else if (ctrl_i.update && match_q) begin
      data_q.threshold <= new_i.threshold;
    end
  end

  assign data_o  = data_q;
  assign after_o = after_q;
  assign match_o = match_q;

endmodule

[rtl/sorted_pair_key_table_insert.sv]
// ----------------------------------------------------------------------------
// sorted_pair_key_table_insert: sorted compound-key table, insert or update
// Top level: handshake, capacity register, sequencer and the row of cells.
// ----------------------------------------------------------------------------
// Each input word carries a key pair and a threshold and produces exactly one
// result word. At the accepting edge all 256 cells compare their entry with
// the key in parallel and keep the outcome; then, in the write state, the
// boundary of the sorted order is found, the cells shift or overwrite in
// place, and the result is loaded into the output register. The write step
// waits only if the previous result is still held in the output register. A
// new input word is taken as soon as the sequencer is back in its idle state,
// even while a result waits downstream. The capacity limit register resets
// to 256 and is written through cfg_we_i; it must only be changed while the
// block is idle. Reset empties the table by clearing the entry count; the
// entry payloads themselves are not cleared, since only entries below the
// count are ever consulted.
module sorted_pair_key_table_insert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sptk_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sptk_pkg::KEY_W-1:0]  primary_key_i,
  input  logic [sptk_pkg::KEY_W-1:0]  secondary_key_i,
  input  logic [sptk_pkg::THR_W-1:0]  threshold_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic                        was_update_o,
  output logic [sptk_pkg::IDX_W-1:0]  position_o,
  output logic [sptk_pkg::CNT_W-1:0]  entry_count_o
);
  import sptk_pkg::*;

  seq_state_e         state_q, state_d;
  logic [CNT_W-1:0]   limit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   eff_limit;
  cell_data_t         word_q;
  cell_ctrl_t         ctrl;

  logic [DEPTH-1:0]   after;
  logic [DEPTH-1:0]   after_prev;
  logic [DEPTH-1:0]   boundary;
  logic [DEPTH-1:0]   match;
  cell_data_t         cell_data [DEPTH];

  logic               accept;
  logic               finish;
  logic               full;
  logic               hit;
  logic [IDX_W-1:0]   pos;

  logic               out_valid_q;
  logic               status_q;
  logic               update_q;
  logic [IDX_W-1:0]   pos_q;
  logic [CNT_W-1:0]   cnt_q;

  // Handshake and sequencing.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign finish     = (state_q == ST_WRITE) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The limit may exceed the table depth; the depth then governs.
  assign eff_limit = (limit_q > DEPTH_CNT) ? DEPTH_CNT : limit_q;
  assign full      = (count_q >= eff_limit);

  // The after flags are a thermometer; its lowest set bit is the slot where
  // the key lives or is to be inserted. A matching key can only sit there.
  assign after_prev = {after[DEPTH-2:0], 1'b0};
  assign boundary   = after & ~after_prev;
  assign hit        = |match;

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (boundary[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  assign ctrl.capture = accept;
  assign ctrl.insert  = finish & ~full & ~hit;
  assign ctrl.update  = finish & ~full & hit;

  assign count_d = ctrl.insert ? count_q + CNT_W'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= DEPTH_CNT;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input word and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.primary   <= primary_key_i;
      word_q.secondary <= secondary_key_i;
      word_q.threshold <= threshold_value_i;
    end
    if (finish) begin
      status_q <= full;
      update_q <= ~full & hit;
      pos_q    <= full ? '0 : pos;
      cnt_q    <= count_d;
    end
  end

  // Row of cells; each takes its lower neighbor's entry when the tail moves.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(g);
    cell_data_t prev_data;

    if (g == 0) begin : g_first
      assign prev_data = word_q;
    end else begin : g_rest
      assign prev_data = cell_data[g-1];
    end

    sptk_cell u_cell (
      .clk_i             (clk_i),
      .rst_ni            (rst_ni),
      .ctrl_i            (ctrl),
      .index_i           (CellIdx),
      .count_i           (count_q),
      .probe_primary_i   (primary_key_i),
      .probe_secondary_i (secondary_key_i),
      .new_i             (word_q),
      .prev_data_i       (prev_data),
      .prev_after_i      (after_prev[g]),
      .data_o            (cell_data[g]),
      .after_o           (after[g]),
      .match_o           (match[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign was_update_o  = update_q;
  assign position_o    = pos_q;
  assign entry_count_o = cnt_q;

endmodule
